>>> hw/rtl/ssl_pkg.sv
package ssl_pkg;

    // Arctangent iterations and table
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int CORDIC_N     = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

    // Vectoring datapath
    localparam int NORM_STEPS = 6;
    localparam int NORM_TOP   = 47;
    localparam int VEC_IN_W   = 51;
    localparam int VEC_W      = 54;
    localparam int ANG_W      = 24;

    // Distance and steering datapath
    localparam int POS_W       = 32;
    localparam int OFS_W       = 33;
    localparam int ERR_W       = 26;
    localparam int DIST_W      = 33;
    localparam int SQ_W        = 66;
    localparam int SQRT_STAGES = 33;
    localparam int REM_W       = 36;
    localparam int NUM_W       = 49;
    localparam int DEN_W       = 29;
    localparam int PROD_W      = 43;
    localparam int DELTA_W     = 32;
    localparam int MAG_W       = 23;
    localparam int SCL_W       = 25;
    localparam int QUO_W       = 17;
    localparam int RCP_W       = 33;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic signed [ANG_W-1:0] HALF_PI_Q20 = 24'sd1647099;
    localparam logic signed [ERR_W-1:0] PI_ERR      = 26'sd3294199;
    localparam logic signed [ERR_W-1:0] TWO_PI_ERR  = 26'sd6588397;

    // Divide by 768 as (v >> 8) * ceil(2^17 / 3) >> 17, exact below 2^17
    localparam logic [QUO_W-1:0] RECIP_3 = 17'd43691;
    localparam logic [SCL_W-1:0] ROUND_768 = 25'd384;
    localparam logic signed [15:0] STEER_LIMIT = 16'sd27307;

    // Reset values of the registers
    localparam logic [15:0] CROSS_GAIN_RST   = 16'd3277;
    localparam logic [15:0] HEADING_GAIN_RST = 16'd3277;
    localparam logic [15:0] SOFT_SPEED_RST   = 16'd5120;
    localparam logic [14:0] MAX_STEER_RST    = 15'd9830;

    typedef enum logic [1:0] {
        CFG_CROSS_GAIN,
        CFG_HEADING_GAIN,
        CFG_SOFT_SPEED,
        CFG_MAX_STEER
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] cross_gain;
        logic [15:0] heading_gain;
        logic [15:0] softening_speed;
        logic [14:0] max_steer;
    } t_cfg;

    typedef struct packed {
        logic signed [OFS_W-1:0] dx;
        logic signed [OFS_W-1:0] dy;
        logic signed [15:0]      heading;
        logic [15:0]             speed;
    } t_item;

    typedef struct packed {
        t_item                   item;
        logic signed [ERR_W-1:0] err;
    } t_side;

    function automatic logic signed [ANG_W-1:0] atan_q20(input int idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:       v = 24'sd823550;
            1:       v = 24'sd486170;
            2:       v = 24'sd256879;
            3:       v = 24'sd130396;
            4:       v = 24'sd65451;
            5:       v = 24'sd32757;
            6:       v = 24'sd16383;
            7:       v = 24'sd8192;
            8:       v = 24'sd4096;
            9:       v = 24'sd2048;
            10:      v = 24'sd1024;
            11:      v = 24'sd512;
            12:      v = 24'sd256;
            13:      v = 24'sd128;
            14:      v = 24'sd64;
            15:      v = 24'sd32;
            16:      v = 24'sd16;
            17:      v = 24'sd8;
            18:      v = 24'sd4;
            19:      v = 24'sd2;
            20:      v = 24'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/ssl_front.sv
module ssl_front import ssl_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [15:0]      i_heading,
    input  logic [15:0]             i_speed,
    input  logic signed [POS_W-1:0] i_target_x,
    input  logic signed [POS_W-1:0] i_target_y,
    input  logic                    i_q_full,
    output logic                    o_q_push,
    output t_item                   o_q_item
);

    logic  r_vld;
    t_item r_item;
    t_item n_item;
    logic  load;

    // Hold the request while the queue is full
    assign o_stall  = r_vld && i_q_full;
    assign o_q_push = r_vld && !i_q_full;
    assign o_q_item = r_item;
    assign load     = !o_stall;

    // Form the offset to the target at full width
    always_comb begin
        n_item.dx      = OFS_W'(i_target_x) - OFS_W'(i_pos_x);
        n_item.dy      = OFS_W'(i_target_y) - OFS_W'(i_pos_y);
        n_item.heading = i_heading;
        n_item.speed   = i_speed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (load) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

>>> hw/rtl/ssl_queue.sv
module ssl_queue import ssl_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_item o_head
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_pop) |-> !i_push)
        else $error("queue written while full");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> !o_empty)
        else $error("queue empty after a lone write");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count above depth");

endmodule

>>> hw/rtl/ssl_vec.sv
module ssl_vec import ssl_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic signed [VEC_IN_W-1:0] i_x,
    input  logic signed [VEC_IN_W-1:0] i_y,
    input  t_side                      i_side,
    output logic                       o_vld,
    output logic signed [ANG_W-1:0]    o_z,
    output t_side                      o_side
);

    localparam int STAGES = 1 + NORM_STEPS + CORDIC_N;

    logic [STAGES-1:0]       r_vld;
    logic [STAGES-1:0]       r_zero;
    t_side                   r_side [STAGES];
    logic signed [VEC_W-1:0] r_x    [STAGES];
    logic signed [VEC_W-1:0] r_y    [STAGES];
    logic signed [ANG_W-1:0] r_z    [STAGES];
    logic signed [VEC_W-1:0] n_x    [STAGES];
    logic signed [VEC_W-1:0] n_y    [STAGES];
    logic signed [ANG_W-1:0] n_z    [STAGES];
    logic signed [VEC_W-1:0] ex;
    logic signed [VEC_W-1:0] ey;

    // Rotate the left half plane into the right one
    assign ex = VEC_W'(i_x);
    assign ey = VEC_W'(i_y);
    always_comb begin
        n_x[0] = ex;
        n_y[0] = ey;
        n_z[0] = '0;
        if (ex < 0) begin
            if (ey >= 0) begin
                n_x[0] = ey;
                n_y[0] = -ex;
                n_z[0] = HALF_PI_Q20;
            end else begin
                n_x[0] = -ey;
                n_y[0] = ex;
                n_z[0] = -HALF_PI_Q20;
            end
        end
    end

    // Scale up until the larger magnitude reaches bit NORM_TOP
    for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
        localparam int J  = 1 + k;
        localparam int SH = 32 >> k;
        logic [VEC_W-1:0] ax;
        logic [VEC_W-1:0] ay;
        logic             shift;
        assign ax    = (r_x[J-1] < 0) ? VEC_W'(-r_x[J-1]) : VEC_W'(r_x[J-1]);
        assign ay    = (r_y[J-1] < 0) ? VEC_W'(-r_y[J-1]) : VEC_W'(r_y[J-1]);
        assign shift = (ax | ay) < (VEC_W'(1) << (NORM_TOP + 1 - SH));
        assign n_x[J] = shift ? (r_x[J-1] <<< SH) : r_x[J-1];
        assign n_y[J] = shift ? (r_y[J-1] <<< SH) : r_y[J-1];
        assign n_z[J] = r_z[J-1];
    end

    // One micro-rotation per stage
    for (genvar i = 0; i < CORDIC_N; i++) begin : g_rot
        localparam int J = 1 + NORM_STEPS + i;
        logic signed [VEC_W-1:0] xs;
        logic signed [VEC_W-1:0] ys;
        logic                    up;
        assign xs = r_x[J-1] >>> i;
        assign ys = r_y[J-1] >>> i;
        assign up = r_y[J-1] > 0;
        assign n_x[J] = up ? (r_x[J-1] + ys) : (r_x[J-1] - ys);
        assign n_y[J] = up ? (r_y[J-1] - xs) : (r_y[J-1] + xs);
        assign n_z[J] = up ? (r_z[J-1] + atan_q20(i)) : (r_z[J-1] - atan_q20(i));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_vld};
        end
    end

    // Advance the datapath and the carried fields
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero    <= {r_zero[STAGES-2:0], (i_x == '0) && (i_y == '0)};
            r_side[0] <= i_side;
            for (int j = 1; j < STAGES; j++) begin
                r_side[j] <= r_side[j-1];
            end
            for (int j = 0; j < STAGES; j++) begin
                r_x[j] <= n_x[j];
                r_y[j] <= n_y[j];
                r_z[j] <= n_z[j];
            end
        end
    end

    assign o_vld  = r_vld[STAGES-1];
    assign o_z    = r_zero[STAGES-1] ? '0 : r_z[STAGES-1];
    assign o_side = r_side[STAGES-1];

endmodule

>>> hw/rtl/ssl_sqrt.sv
module ssl_sqrt import ssl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [SQ_W-1:0]   i_val,
    input  t_side             i_side,
    output logic              o_vld,
    output logic [DIST_W-1:0] o_root,
    output t_side             o_side
);

    logic [SQRT_STAGES-1:0] r_vld;
    t_side                  r_side [SQRT_STAGES];
    logic [SQ_W-1:0]        r_val  [SQRT_STAGES];
    logic [REM_W-1:0]       r_rem  [SQRT_STAGES];
    logic [DIST_W-1:0]      r_root [SQRT_STAGES];
    logic [REM_W-1:0]       n_rem  [SQRT_STAGES];
    logic [DIST_W-1:0]      n_root [SQRT_STAGES];

    // Restoring root, one bit pair per stage, top pair first
    for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_step
        localparam int P = SQRT_STAGES - 1 - j;
        logic [SQ_W-1:0]   val;
        logic [REM_W-1:0]  rem_in;
        logic [DIST_W-1:0] root_in;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        if (j == 0) begin : g_first
            assign val     = i_val;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign val     = r_val[j-1];
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
        end
        assign rem_sh = {rem_in[REM_W-3:0], val[2*P+1:2*P]};
        assign trial  = REM_W'({root_in, 2'b01});
        assign n_rem[j]  = (rem_sh >= trial) ? (rem_sh - trial) : rem_sh;
        assign n_root[j] = {root_in[DIST_W-2:0], rem_sh >= trial};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[SQRT_STAGES-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_val[0]  <= i_val;
            for (int j = 1; j < SQRT_STAGES; j++) begin
                r_side[j] <= r_side[j-1];
                r_val[j]  <= r_val[j-1];
            end
            for (int j = 0; j < SQRT_STAGES; j++) begin
                r_rem[j]  <= n_rem[j];
                r_root[j] <= n_root[j];
            end
        end
    end

    assign o_vld  = r_vld[SQRT_STAGES-1];
    assign o_root = r_root[SQRT_STAGES-1];
    assign o_side = r_side[SQRT_STAGES-1];

endmodule

>>> hw/rtl/ssl_back.sv
module ssl_back import ssl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_q_empty,
    input  t_item              i_q_head,
    output logic               o_q_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_steer_cmd
);

    logic en;

    logic                    v1_vld;
    logic signed [ANG_W-1:0] v1_z;
    t_side                   v1_side;
    t_side                   side0;

    logic                    r1_vld;
    logic [SQ_W-1:0]         r1_sqx;
    logic [SQ_W-1:0]         r1_sqy;
    t_side                   r1_side;
    logic [OFS_W-1:0]        ax;
    logic [OFS_W-1:0]        ay;
    logic signed [ERR_W-1:0] err;
    t_side                   n1_side;

    logic            r2_vld;
    logic [SQ_W-1:0] r2_sum;
    t_side           r2_side;

    logic              s_vld;
    logic [DIST_W-1:0] s_root;
    t_side             s_side;

    logic             r3_vld;
    logic [NUM_W-1:0] r3_num;
    logic [DEN_W-1:0] r3_den;
    t_side            r3_side;

    logic                    v2_vld;
    logic signed [ANG_W-1:0] v2_z;
    t_side                   v2_side;

    logic                     r4_vld;
    logic signed [PROD_W-1:0] r4_prod;
    logic signed [ANG_W-1:0]  r4_cte;

    logic                      r5_vld;
    logic signed [DELTA_W-1:0] r5_delta;
    logic [PROD_W-1:0]         pm;
    logic [PROD_W-1:0]         rnd;
    logic signed [DELTA_W-1:0] hterm;
    logic signed [DELTA_W-1:0] draw;
    logic signed [DELTA_W-1:0] lim;
    logic signed [DELTA_W-1:0] n5_delta;

    logic             r6_vld;
    logic             r6_neg;
    logic [QUO_W-1:0] r6_n;
    logic [MAG_W-1:0] mag;
    logic [SCL_W-1:0] scl;

    logic               r_out_vld;
    logic signed [15:0] r_out_steer;
    logic [RCP_W-1:0]   qprod;
    logic [15:0]        quo;

    // Whole back pipeline moves unless the result is held
    assign en      = !r_out_vld || !i_stall;
    assign o_q_pop = en && !i_q_empty;

    always_comb begin
        side0.item = i_q_head;
        side0.err  = '0;
    end

    // Path heading
    ssl_vec u_path (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (!i_q_empty),
        .i_x    (VEC_IN_W'(i_q_head.dx)),
        .i_y    (VEC_IN_W'(i_q_head.dy)),
        .i_side (side0),
        .o_vld  (v1_vld),
        .o_z    (v1_z),
        .o_side (v1_side)
    );

    // Wrap the heading error, square the offsets
    always_comb begin
        ax = (v1_side.item.dx < 0) ? OFS_W'(-v1_side.item.dx) : OFS_W'(v1_side.item.dx);
        ay = (v1_side.item.dy < 0) ? OFS_W'(-v1_side.item.dy) : OFS_W'(v1_side.item.dy);
        err = ERR_W'(v1_z) - (ERR_W'(v1_side.item.heading) <<< 7);
        for (int k = 0; k < 3; k++) begin
            if (err > PI_ERR) begin
                err = err - TWO_PI_ERR;
            end else if (err <= -PI_ERR) begin
                err = err + TWO_PI_ERR;
            end
        end
        n1_side     = v1_side;
        n1_side.err = err;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_sqx  <= SQ_W'(ax) * SQ_W'(ax);
            r1_sqy  <= SQ_W'(ay) * SQ_W'(ay);
            r1_side <= n1_side;
            r2_sum  <= r1_sqx + r1_sqy;
            r2_side <= r1_side;
        end
    end

    ssl_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r2_vld),
        .i_val  (r2_sum),
        .i_side (r2_side),
        .o_vld  (s_vld),
        .o_root (s_root),
        .o_side (s_side)
    );

    // Form the cross-track numerator and denominator
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_num  <= NUM_W'(i_cfg.cross_gain) * NUM_W'(s_root);
            r3_den  <= DEN_W'(17'(i_cfg.softening_speed) + 17'(s_side.item.speed)) << 12;
            r3_side <= s_side;
        end
    end

    ssl_vec u_cte (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r3_vld),
        .i_x    (VEC_IN_W'(r3_den)),
        .i_y    (VEC_IN_W'(r3_num)),
        .i_side (r3_side),
        .o_vld  (v2_vld),
        .o_z    (v2_z),
        .o_side (v2_side)
    );

    // Heading term, rounding, saturation
    always_comb begin
        pm       = (r4_prod < 0) ? PROD_W'(-r4_prod) : PROD_W'(r4_prod);
        rnd      = (pm + PROD_W'(2048)) >> 12;
        hterm    = (r4_prod < 0) ? -DELTA_W'(rnd) : DELTA_W'(rnd);
        draw     = hterm + DELTA_W'(r4_cte);
        lim      = $signed(DELTA_W'({i_cfg.max_steer, 7'b0}));
        n5_delta = draw;
        if (draw > lim) begin
            n5_delta = lim;
        end else if (draw < -lim) begin
            n5_delta = -lim;
        end
    end

    // Scale by 5/768 with rounding
    always_comb begin
        mag   = (r5_delta < 0) ? MAG_W'(-r5_delta) : MAG_W'(r5_delta);
        scl   = SCL_W'(mag) * SCL_W'(5) + ROUND_768;
        qprod = RCP_W'(r6_n) * RCP_W'(RECIP_3);
        quo   = qprod[RCP_W-1:17];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_prod     <= PROD_W'($signed({1'b0, i_cfg.heading_gain})) *
                           PROD_W'(v2_side.err);
            r4_cte      <= v2_z;
            r5_delta    <= n5_delta;
            r6_n        <= scl[SCL_W-1:8];
            r6_neg      <= r5_delta < 0;
            r_out_steer <= r6_neg ? -$signed(quo) : $signed(quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r6_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r1_vld    <= v1_vld;
            r2_vld    <= r1_vld;
            r3_vld    <= s_vld;
            r4_vld    <= v2_vld;
            r5_vld    <= r4_vld;
            r6_vld    <= r5_vld;
            r_out_vld <= r6_vld;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_steer_cmd = r_out_steer;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_steer <= STEER_LIMIT && r_out_steer >= -STEER_LIMIT))
        else $error("steering command out of range");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_stall) |=> (r_out_vld && $stable(r_out_steer)))
        else $error("held result lost");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r6_vld))
        else $error("result without an item behind it");

endmodule

>>> hw/rtl/stanley_steering_law.sv
// Channel  Valid     Stall     Payload
// input    i_valid   o_stall   i_pos_x i_pos_y i_heading i_speed i_target_x i_target_y
// output   o_valid   i_stall   o_steer_cmd
// config   i_cfg_wr_en  -      i_cfg_index i_cfg_data
//
// One pose per clock sustained while the output is not stalled; the back pipeline
// holds two 23-stage arctangent pipelines and the 33-stage square root.
// Reset is synchronous, active low; registers return to their defaults.
// A four-entry queue separates the input register from the back pipeline,
// which halts as a whole while its output register is stalled.
module stanley_steering_law import ssl_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [15:0]      i_heading,
    input  logic [15:0]             i_speed,
    input  logic signed [POS_W-1:0] i_target_x,
    input  logic signed [POS_W-1:0] i_target_y,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [15:0]      o_steer_cmd,
    input  logic                    i_cfg_wr_en,
    input  logic [1:0]              i_cfg_index,
    input  logic [15:0]             i_cfg_data
);

    t_cfg  r_cfg;
    logic  q_full;
    logic  q_empty;
    logic  q_push;
    logic  q_pop;
    t_item q_in;
    t_item q_head;

    // Write the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cross_gain      <= CROSS_GAIN_RST;
            r_cfg.heading_gain    <= HEADING_GAIN_RST;
            r_cfg.softening_speed <= SOFT_SPEED_RST;
            r_cfg.max_steer       <= MAX_STEER_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CROSS_GAIN:   r_cfg.cross_gain      <= i_cfg_data;
                CFG_HEADING_GAIN: r_cfg.heading_gain    <= i_cfg_data;
                CFG_SOFT_SPEED:   r_cfg.softening_speed <= i_cfg_data;
                CFG_MAX_STEER:    r_cfg.max_steer       <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    ssl_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_pos_x   (i_pos_x),
        .i_pos_y   (i_pos_y),
        .i_heading (i_heading),
        .i_speed   (i_speed),
        .i_target_x(i_target_x),
        .i_target_y(i_target_y),
        .i_q_full  (q_full),
        .o_q_push  (q_push),
        .o_q_item  (q_in)
    );

    ssl_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_item (q_in),
        .i_pop  (q_pop),
        .o_full (q_full),
        .o_empty(q_empty),
        .o_head (q_head)
    );

    ssl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_empty  (q_empty),
        .i_q_head   (q_head),
        .o_q_pop    (q_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_steer_cmd(o_steer_cmd)
    );

endmodule
